[rtl/set_assoc_icache_tag_lru_defines.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the set-associative tag store with LRU.
// Shared helpers for concurrent checks on clk_i with reset rst_ni.
// ---------------------------------------------------------------------------
`ifndef SET_ASSOC_ICACHE_TAG_LRU_DEFINES_SVH
`define SET_ASSOC_ICACHE_TAG_LRU_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SATL_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define SATL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/satl_pkg.sv]
// ---------------------------------------------------------------------------
// satl_pkg
// Shared constants and controller/datapath interface types of the tag store.
// ---------------------------------------------------------------------------
`default_nettype none

package satl_pkg;

  localparam int unsigned NUM_SETS_DEF         = 64;
  localparam int unsigned NUM_WAYS_DEF         = 4;
  localparam int unsigned LINE_OFFSET_BITS_DEF = 5;

  localparam int unsigned ADDR_W       = 32;
  localparam int unsigned PENALTY_W    = 8;
  localparam int unsigned WAY_FIELD_W  = 2;
  localparam int unsigned OUT_TDATA_W  = 16;

  localparam logic [PENALTY_W-1:0] MISS_PENALTY_RST = 8'd50;

  // Commands from the controller; at most one is active in a cycle.
  typedef struct packed {
    logic clear;   // write an all-zero row during the post-reset sweep
    logic load;    // capture the address and read its set
    logic update;  // write back the set and load the result register
  } satl_cmd_t;

  typedef struct packed {
    logic clear_last;  // the sweep is at the last set
  } satl_sts_t;

endpackage

`default_nettype wire

[rtl/set_assoc_icache_tag_lru.sv]
// ---------------------------------------------------------------------------
// set_assoc_icache_tag_lru
// Tag store of a set-associative instruction cache with rank-based true LRU.
// Each input transaction on s_axis carries one fetch address; each output
// transaction on m_axis carries hit, stall cycles and the way hit or filled.
// A transaction is accepted when its tvalid and tready are both high.
// After reset the block sweeps the set memory, one set per cycle, through
// all NUM_SETS sets (64 by default) with s_axis_tready low; configuration
// writes are taken during the sweep as at any time.
// On acceptance the set row is read into a register; in the LOOKUP state
// the row is updated and the result is registered once the output register
// is free. No further address is taken until the lookup is done, set by the
// read-modify-write of the set memory.
// If the receiver stalls, the result waits in the output register; one more
// address may be accepted and waits after its read until the register frees.
// cfg_* writes the miss penalty (reset value 50); cfg_ready_o is always high.
// ---------------------------------------------------------------------------
`default_nettype none

module set_assoc_icache_tag_lru #(
  parameter int unsigned NUM_SETS         = satl_pkg::NUM_SETS_DEF,
  parameter int unsigned NUM_WAYS         = satl_pkg::NUM_WAYS_DEF,
  parameter int unsigned LINE_OFFSET_BITS = satl_pkg::LINE_OFFSET_BITS_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              s_axis_tvalid,
  output      logic                              s_axis_tready,
  // [31:0] fetch_address
  input  wire logic [satl_pkg::ADDR_W-1:0]       s_axis_tdata,
  output      logic                              m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // [0] hit, [8:1] stall_cycles, [10:9] way_used, [15:11] zero
  output      logic [satl_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  input  wire logic                              cfg_valid_i,
  output      logic                              cfg_ready_o,
  input  wire logic [satl_pkg::PENALTY_W-1:0]    cfg_data_i
);
  import satl_pkg::*;

  localparam int unsigned PAD_W = OUT_TDATA_W - 1 - PENALTY_W - WAY_FIELD_W;

  satl_cmd_t              cmd;
  satl_sts_t              sts;
  logic                   out_hit;
  logic [PENALTY_W-1:0]   out_stall;
  logic [WAY_FIELD_W-1:0] out_way;

  assign cfg_ready_o  = 1'b1;
  assign m_axis_tdata = {{PAD_W{1'b0}}, out_way, out_stall, out_hit};

  satl_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .cmd_o     (cmd),
    .sts_i     (sts)
  );

  satl_dp #(
    .NUM_SETS         (NUM_SETS),
    .NUM_WAYS         (NUM_WAYS),
    .LINE_OFFSET_BITS (LINE_OFFSET_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .addr_i      (s_axis_tdata),
    .cfg_we_i    (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .out_hit_o   (out_hit),
    .out_stall_o (out_stall),
    .out_way_o   (out_way)
  );

endmodule

`default_nettype wire

[rtl/satl_dp.sv]
// ---------------------------------------------------------------------------
// satl_dp
// Datapath: set memories, hit detection, victim choice, rank update and the
// result register.
// ---------------------------------------------------------------------------
`default_nettype none

module satl_dp #(
  parameter int unsigned NUM_SETS         = 64,
  parameter int unsigned NUM_WAYS         = 4,
  parameter int unsigned LINE_OFFSET_BITS = 5
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire satl_pkg::satl_cmd_t                 cmd_i,
  output      satl_pkg::satl_sts_t                 sts_o,
  input  wire logic [satl_pkg::ADDR_W-1:0]         addr_i,
  input  wire logic                                cfg_we_i,
  input  wire logic [satl_pkg::PENALTY_W-1:0]      cfg_data_i,
  output      logic                                out_hit_o,
  output      logic [satl_pkg::PENALTY_W-1:0]      out_stall_o,
  output      logic [satl_pkg::WAY_FIELD_W-1:0]    out_way_o
);
  import satl_pkg::*;

  localparam int unsigned SET_BITS = $clog2(NUM_SETS);
  localparam int unsigned SET_W    = (SET_BITS == 0) ? 1 : SET_BITS;
  localparam int unsigned TAG_W    = ADDR_W - LINE_OFFSET_BITS - SET_BITS;
  localparam int unsigned WAY_W    = $clog2(NUM_WAYS);
  localparam logic [ADDR_W-1:0] SET_MASK = ADDR_W'((64'd1 << SET_BITS) - 64'd1);
  localparam logic [WAY_W-1:0]  TOP_RANK = WAY_W'(NUM_WAYS - 1);
  localparam logic [SET_W-1:0]  LAST_SET = SET_W'(NUM_SETS - 1);

  // Set memories, one row per set, all ways side by side.
  logic [NUM_WAYS-1:0]            mem_valid_q [NUM_SETS];
  logic [NUM_WAYS-1:0][TAG_W-1:0] mem_tag_q   [NUM_SETS];
  logic [NUM_WAYS-1:0][WAY_W-1:0] mem_rank_q  [NUM_SETS];

  logic [NUM_WAYS-1:0]            rd_valid_q;
  logic [NUM_WAYS-1:0][TAG_W-1:0] rd_tag_q;
  logic [NUM_WAYS-1:0][WAY_W-1:0] rd_rank_q;

  logic [NUM_WAYS-1:0]            wr_valid;
  logic [NUM_WAYS-1:0][TAG_W-1:0] wr_tag;
  logic [NUM_WAYS-1:0][WAY_W-1:0] wr_rank;

  logic [SET_W-1:0]     clr_cnt_q;
  logic [SET_W-1:0]     set_raw;
  logic [SET_W-1:0]     set_idx;
  logic [SET_W-1:0]     idx_q;
  logic [TAG_W-1:0]     tag_in;
  logic [TAG_W-1:0]     tag_q;
  logic [PENALTY_W-1:0] penalty_q;

  logic [NUM_WAYS-1:0] match;
  logic                hit;
  logic                has_inv;
  logic [WAY_W-1:0]    hit_way;
  logic [WAY_W-1:0]    inv_way;
  logic [WAY_W-1:0]    lru_way;
  logic [WAY_W-1:0]    sel_way;
  logic [WAY_W-1:0]    floor_rank;

  // An index field at or above the set count wraps once; it is below twice
  // the count, so one subtraction suffices.
  always_comb begin
    set_raw = SET_W'((addr_i >> LINE_OFFSET_BITS) & SET_MASK);
    set_idx = set_raw;
    if (ADDR_W'(set_raw) >= ADDR_W'(NUM_SETS)) begin
      set_idx = set_raw - SET_W'(NUM_SETS);
    end
  end

  assign tag_in = TAG_W'(addr_i >> (LINE_OFFSET_BITS + SET_BITS));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
      penalty_q <= MISS_PENALTY_RST;
    end else begin
      if (cmd_i.clear) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
      end
      if (cfg_we_i) begin
        penalty_q <= cfg_data_i;
      end
    end
  end

  assign sts_o.clear_last = (clr_cnt_q == LAST_SET);

  // Ranks of the valid ways in a set are always distinct and packed at the
  // top, so a full set has exactly one way at rank zero: that is the LRU way.
  always_comb begin
    match   = '0;
    hit_way = '0;
    inv_way = '0;
    lru_way = '0;
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      match[w] = rd_valid_q[w] && (rd_tag_q[w] == tag_q);
      if (match[w]) begin
        hit_way = WAY_W'(w);
      end
      if (!rd_valid_q[w]) begin
        inv_way = WAY_W'(w);
      end
      if (rd_rank_q[w] == '0) begin
        lru_way = WAY_W'(w);
      end
    end
    hit        = |match;
    has_inv    = ~&rd_valid_q;
    sel_way    = hit ? hit_way : (has_inv ? inv_way : lru_way);
    floor_rank = hit ? rd_rank_q[hit_way] : '0;
    for (int w = 0; w < NUM_WAYS; w++) begin
      if (sel_way == WAY_W'(w)) begin
        wr_valid[w] = 1'b1;
        wr_tag[w]   = hit ? rd_tag_q[w] : tag_q;
        wr_rank[w]  = TOP_RANK;
      end else begin
        wr_valid[w] = rd_valid_q[w];
        wr_tag[w]   = rd_tag_q[w];
        wr_rank[w]  = (rd_valid_q[w] && (rd_rank_q[w] > floor_rank)) ?
                      rd_rank_q[w] - 1'b1 : rd_rank_q[w];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clear) begin
      mem_valid_q[clr_cnt_q] <= '0;
      mem_tag_q[clr_cnt_q]   <= '0;
      mem_rank_q[clr_cnt_q]  <= '0;
    end else if (cmd_i.update) begin
      mem_valid_q[idx_q] <= wr_valid;
      mem_tag_q[idx_q]   <= wr_tag;
      mem_rank_q[idx_q]  <= wr_rank;
    end
    if (cmd_i.load) begin
      rd_valid_q <= mem_valid_q[set_idx];
      rd_tag_q   <= mem_tag_q[set_idx];
      rd_rank_q  <= mem_rank_q[set_idx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      idx_q <= set_idx;
      tag_q <= tag_in;
    end
    if (cmd_i.update) begin
      out_hit_o   <= hit;
      out_stall_o <= hit ? '0 : penalty_q;
      out_way_o   <= WAY_FIELD_W'(sel_way);
    end
  end

endmodule

`default_nettype wire

[rtl/satl_ctrl.sv]
// ---------------------------------------------------------------------------
// satl_ctrl
// Controller: post-reset sweep, lookup sequencing and output handshake.
// ---------------------------------------------------------------------------
`default_nettype none
`include "set_assoc_icache_tag_lru_defines.svh"

module satl_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_valid_i,
  output      logic                s_ready_o,
  output      logic                m_valid_o,
  input  wire logic                m_ready_i,
  output      satl_pkg::satl_cmd_t cmd_o,
  input  wire satl_pkg::satl_sts_t sts_i
);
  import satl_pkg::*;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP
  } state_e;

  state_e state_q;
  state_e state_d;
  logic   m_valid_q;
  logic   m_valid_d;
  logic   out_free;

  assign out_free  = !m_valid_q || m_ready_i;
  assign s_ready_o = (state_q == ST_IDLE);
  assign m_valid_o = m_valid_q;

  always_comb begin
    state_d      = state_q;
    cmd_o        = '0;
    m_valid_d    = m_valid_q && !m_ready_i;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (sts_i.clear_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (s_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        // Hold the read row until the result register can take the new result.
        if (out_free) begin
          cmd_o.update = 1'b1;
          m_valid_d    = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      m_valid_q <= m_valid_d;
    end
  end

  `SATL_ASSERT_NOW(a_cmd_excl, 1'b1, $onehot0({cmd_o.clear, cmd_o.load, cmd_o.update}),
                   "controller issued more than one command")
  `SATL_ASSERT_NEXT(a_update_shows, cmd_o.update, m_valid_o,
                    "result not presented after update")
  `SATL_ASSERT_NEXT(a_load_busy, cmd_o.load, !s_ready_o,
                    "input accepted again during a lookup")
  `SATL_ASSERT_NOW(a_clear_quiet, cmd_o.clear, !m_valid_o && !s_ready_o,
                   "transaction activity during the clearing sweep")

endmodule

`default_nettype wire
